// ----- src/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Depth stack average package
// Shared widths, constant tables and the merge result type.
// ----------------------------------------------------------------------------
package dsa_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int SLOT_COUNT = 8;
	localparam int DEPTH_W    = 16;
	localparam int COUNT_W    = 4;
	localparam int SUM_W      = DEPTH_W + $clog2(SLOT_COUNT);
	localparam int SCORE_W    = 8;
	localparam int RECIP_SH   = 22;
	localparam int RECIP_W    = RECIP_SH + 1;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;
	localparam int REG_IDX_W  = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = '0;
	localparam logic [COUNT_W-1:0]   FRAMES_RESET      = COUNT_W'(8);

	typedef logic [DEPTH_W-1:0] depth_t;
	typedef depth_t             depth_arr_t [SLOT_COUNT];
	typedef logic [SLOT_COUNT-1:0] flag_vec_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] valid;
		logic [COUNT_W-1:0] zeros;
	} merge_t;

	// Reciprocals ceil(2^22 / d), exact for every sum below 2^19 and d up to eight.
	localparam logic [RECIP_W-1:0] RECIP_TAB [16] = '{
		23'd0,       23'd4194304, 23'd2097152, 23'd1398102,
		23'd1048576, 23'd838861,  23'd699051,  23'd599187,
		23'd524288,  23'd0,       23'd0,       23'd0,
		23'd0,       23'd0,       23'd0,       23'd0
	};

	// Score step per missing sample: 240 div n.
	localparam logic [SCORE_W-1:0] SCORE_TAB [16] = '{
		8'd0,   8'd240, 8'd120, 8'd80,
		8'd60,  8'd48,  8'd40,  8'd34,
		8'd30,  8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0
	};

endpackage

// ----- src/dsa_lane.sv -----
// ----------------------------------------------------------------------------
// Depth stack average lane
// Masks one frame's sample and flags it as missing when it counts and is zero.
// ----------------------------------------------------------------------------
module dsa_lane
	import dsa_pkg::*;
(
	input  logic   clk,
	input  logic   enable,
	input  depth_t sample,
	output depth_t masked_s1,
	output logic   zero_s1
);

	always_ff @(posedge clk) begin
		masked_s1 <= enable ? sample : '0;
		zero_s1   <= enable && (sample == '0);
	end

endmodule

// ----- src/dsa_merge.sv -----
// ----------------------------------------------------------------------------
// Depth stack average merge
// Adds the lane samples and counts missing ones over two pipeline stages.
// ----------------------------------------------------------------------------
module dsa_merge
	import dsa_pkg::*;
(
	input  logic               clk,
	input  depth_arr_t         masked_s1,
	input  flag_vec_t          zero_s1,
	input  logic [COUNT_W-1:0] frames_s1,
	output merge_t             merge_s3
);

	localparam int PAIRS = SLOT_COUNT / 2;

	logic [DEPTH_W:0]     pair_s2 [PAIRS];
	logic [COUNT_W-1:0]   zeros_s2;
	logic [COUNT_W-1:0]   frames_s2;
	logic [SUM_W-1:0]     total;

	always_ff @(posedge clk) begin
		for (int p = 0; p < PAIRS; p++) begin
			pair_s2[p] <= {1'b0, masked_s1[2*p]} + {1'b0, masked_s1[2*p+1]};
		end
		zeros_s2  <= COUNT_W'($countones(zero_s1));
		frames_s2 <= frames_s1;
	end

	always_comb begin
		total = '0;
		for (int p = 0; p < PAIRS; p++) begin
			total = total + SUM_W'(pair_s2[p]);
		end
	end

	always_ff @(posedge clk) begin
		merge_s3.sum   <= total;
		merge_s3.zeros <= zeros_s2;
		merge_s3.valid <= frames_s2 - zeros_s2;
	end

endmodule

// ----- src/dsa_divide.sv -----
// ----------------------------------------------------------------------------
// Depth stack average divider
// Divides the sum by the valid count through a reciprocal table and multiply.
// ----------------------------------------------------------------------------
module dsa_divide
	import dsa_pkg::*;
(
	input  logic   clk,
	input  merge_t merge_s3,
	output depth_t mean_s5
);

	logic [PROD_W-1:0] prod_s4;

	// A valid count of zero reads a zero reciprocal, so the mean comes out as zero.
	always_ff @(posedge clk) begin
		prod_s4 <= PROD_W'(merge_s3.sum) * PROD_W'(RECIP_TAB[merge_s3.valid]);
		mean_s5 <= prod_s4[RECIP_SH +: DEPTH_W];
	end

endmodule

// ----- src/depth_stack_average_top.sv -----
// ----------------------------------------------------------------------------
// Depth stack average top level
// Masked temporal mean of up to eight stacked depth samples of one pixel.
// ----------------------------------------------------------------------------
// A request is taken on every clock cycle in which start is high; busy never
// rises, so pixels may stream at one per clock. Each request produces exactly
// one result, shown for one cycle with done high; the receiver cannot
// stall, so it must take every result as it appears. Every result passes
// through the five-stage pipeline: lane masking, pair sums, final
// sum and counts, the reciprocal multiply and the output register. The
// frames_in_use register is written over the APB port and should only be
// changed while no request is in flight; zero is treated as one frame and
// values above the frame count saturate to eight.
module depth_stack_average_top
	import dsa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// Request side
	input  logic                start,
	output logic                busy,
	input  logic [DEPTH_W-1:0]  depth_a,
	input  logic [DEPTH_W-1:0]  depth_b,
	input  logic [DEPTH_W-1:0]  depth_c,
	input  logic [DEPTH_W-1:0]  depth_d,
	input  logic [DEPTH_W-1:0]  depth_e,
	input  logic [DEPTH_W-1:0]  depth_f,
	input  logic [DEPTH_W-1:0]  depth_g,
	input  logic [DEPTH_W-1:0]  depth_h,
	// Result side
	output logic                done,
	output logic [DEPTH_W-1:0]  mean_depth,
	output logic [SCORE_W-1:0]  missing_score
);

	logic [COUNT_W-1:0]   frames_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic [COUNT_W-1:0]   frames_eff;
	logic [COUNT_W-1:0]   frames_s1;
	logic [4:0]           valid_q;
	depth_arr_t           samples;
	depth_arr_t           masked_s1;
	flag_vec_t            zero_s1;
	merge_t               merge_s3;
	logic [SCORE_W-1:0]   score_s4;
	logic [SCORE_W-1:0]   score_s5;
	depth_t               mean_s5;

	// The configuration port never waits, so a write lands on the access cycle.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (wr_en && (reg_idx == REG_FRAMES_IN_USE)) begin
			frames_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAMES_IN_USE: prdata = DATA_W'(frames_q);
			default:           prdata = '0;
		endcase
	end

	// The usable frame count is clamped to the range one to the frame limit.
	always_comb begin
		if (frames_q == '0) begin
			frames_eff = COUNT_W'(1);
		end else if (frames_q > COUNT_W'(MAX_FRAMES)) begin
			frames_eff = COUNT_W'(MAX_FRAMES);
		end else begin
			frames_eff = frames_q;
		end
	end

	// The pipeline has no back-pressure, so requests are always welcome.
	assign busy = 1'b0;

	assign samples[0] = depth_a;
	assign samples[1] = depth_b;
	assign samples[2] = depth_c;
	assign samples[3] = depth_d;
	assign samples[4] = depth_e;
	assign samples[5] = depth_f;
	assign samples[6] = depth_g;
	assign samples[7] = depth_h;

	// One lane per stacked frame; lanes at or beyond the frame count pass zero
	// and are not counted as missing.
	for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_lane
		dsa_lane u_lane (
			.clk       (clk),
			.enable    ((k < MAX_FRAMES) && (COUNT_W'(k) < frames_eff)),
			.sample    (samples[k]),
			.masked_s1 (masked_s1[k]),
			.zero_s1   (zero_s1[k])
		);
	end

	always_ff @(posedge clk) begin
		frames_s1 <= frames_eff;
	end

	dsa_merge u_merge (
		.clk       (clk),
		.masked_s1 (masked_s1),
		.zero_s1   (zero_s1),
		.frames_s1 (frames_s1),
		.merge_s3  (merge_s3)
	);

	dsa_divide u_divide (
		.clk      (clk),
		.merge_s3 (merge_s3),
		.mean_s5  (mean_s5)
	);

	// The missing-data score runs beside the divider so that both leave together.
	// The product never exceeds 240, so eight bits hold it.
	always_ff @(posedge clk) begin
		score_s4 <= SCORE_W'(SCORE_TAB[merge_s3.valid + merge_s3.zeros] * merge_s3.zeros);
		score_s5 <= score_s4;
	end

	// Request markers follow the data through the five stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[3:0], start && !busy};
		end
	end

	assign done          = valid_q[4];
	assign mean_depth    = mean_s5;
	assign missing_score = score_s5;

	// Every accepted request produces a result after the pipeline latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##5 done)
		else $error("accepted request produced no result");

	// A nonzero mean means at least one valid sample, so the score stays below full.
	a_mean_score: assert property (@(posedge clk) disable iff (!arst_n)
		done && (mean_depth != '0) |-> (missing_score < SCORE_W'(240)))
		else $error("full missing score with a nonzero mean");

	// The score never exceeds its full value.
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (missing_score <= SCORE_W'(240)))
		else $error("missing score out of range");

endmodule
